/* hdl/mcrc_pkg.sv */
// Shared constants and types for the motor command ramp controller.
`default_nettype none

package mcrc_pkg;

    // Field widths
    localparam int DIR_W    = 3;
    localparam int DUTY_W   = 7;
    localparam int SPEED_W  = 8;
    localparam int CUE_W    = 2;
    localparam int PERIOD_W = 10;
    localparam int TICKS_W  = 16;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 16;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Bridge direction codes
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT     = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_STOP     = 3'd4;
    localparam logic [DIR_W-1:0] DIR_BRAKE    = 3'd5;

    // Buzzer cue codes
    localparam logic [CUE_W-1:0] CUE_NONE   = 2'd0;
    localparam logic [CUE_W-1:0] CUE_MOVING = 2'd1;
    localparam logic [CUE_W-1:0] CUE_HALTED = 2'd2;

    // Request kind carried on tuser
    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [DUTY_W-1:0] FULL_DUTY = 7'd100;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD = 10'd1000;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_RAMP_STEP    = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_RAMP_PERIOD  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_DEFAULT_DUTY = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_PIVOT_DUTY   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_PIVOT_TICKS  = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_DRIVE_TICKS  = 3'd5;

    // Command request payload, lowest field last
    typedef struct packed {
        logic [3:0]               pad;
        logic                     pivot;
        logic signed [SPEED_W-1:0] speed;
        logic [DIR_W-1:0]         direction;
    } t_cmd;

    // Result payload, lowest field last
    typedef struct packed {
        logic [1:0]        pad;
        logic              timed_busy;
        logic              rejected;
        logic [CUE_W-1:0]  cue;
        logic [DUTY_W-1:0] enable_duty;
        logic [DIR_W-1:0]  drive_direction;
    } t_result;

endpackage

`default_nettype wire

/* hdl/motor_command_ramp_controller.sv */
// Motor command ramp controller: duty slew limiter with timed direct-drive moves.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle unless the result side stalls; the state update is
// one pass of compares and adds between the input register and the result register.
// Reset (synchronous, active low): both stages empty, duties zero, direction STOP,
// counters zero, configuration registers back to their defaults.
`default_nettype none

module motor_command_ramp_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_data,
    // Request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // direction[2:0], speed[10:3], pivot[11], zero
    input  wire logic [0:0]  s_axis_tuser,  // func[0]
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // drive_direction[2:0], enable_duty[9:3],
                                            // cue[11:10], rejected[12], timed_busy[13], zero
);

    // Configuration registers
    logic [6:0]  r_ramp_step;
    logic [9:0]  r_ramp_period;
    logic [6:0]  r_default_duty;
    logic [6:0]  r_pivot_duty;
    logic [15:0] r_pivot_ticks;
    logic [15:0] r_drive_ticks;

    // Pipeline registers
    logic                 r_in_valid;
    mcrc_pkg::t_cmd       r_in_cmd;
    logic                 r_in_func;
    logic                 r_out_valid;
    mcrc_pkg::t_result    r_out;

    // Controller state
    logic [6:0]  r_target_duty, n_target_duty;
    logic [6:0]  r_live_duty, n_live_duty;
    logic [2:0]  r_active_dir, n_active_dir;
    logic [2:0]  r_last_dir, n_last_dir;
    logic [9:0]  r_ramp_cnt, n_ramp_cnt;
    logic [15:0] r_ticks_left, n_ticks_left;
    logic        r_timed, n_timed;
    mcrc_pkg::t_result n_out;

    logic advance;

    // Saturated configuration values
    logic [6:0]  step_c, default_c, pivot_c;
    logic [9:0]  period_c;
    logic [15:0] pivot_ticks_c, drive_ticks_c;

    assign step_c   = (r_ramp_step == 7'd0) ? 7'd1 :
                      (r_ramp_step > mcrc_pkg::FULL_DUTY) ? mcrc_pkg::FULL_DUTY : r_ramp_step;
    assign period_c = (r_ramp_period == 10'd0) ? 10'd1 :
                      (r_ramp_period > mcrc_pkg::MAX_PERIOD) ? mcrc_pkg::MAX_PERIOD
                                                             : r_ramp_period;
    assign default_c = (r_default_duty > mcrc_pkg::FULL_DUTY) ? mcrc_pkg::FULL_DUTY
                                                              : r_default_duty;
    assign pivot_c   = (r_pivot_duty > mcrc_pkg::FULL_DUTY) ? mcrc_pkg::FULL_DUTY
                                                            : r_pivot_duty;
    assign pivot_ticks_c = (r_pivot_ticks == 16'd0) ? 16'd1 : r_pivot_ticks;
    assign drive_ticks_c = (r_drive_ticks == 16'd0) ? 16'd1 : r_drive_ticks;

    // Handshake: the input stage moves on whenever the result register is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step    <= 7'd5;
            r_ramp_period  <= 10'd20;
            r_default_duty <= 7'd70;
            r_pivot_duty   <= 7'd60;
            r_pivot_ticks  <= 16'd500;
            r_drive_ticks  <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mcrc_pkg::REG_RAMP_STEP:    r_ramp_step    <= i_cfg_data[6:0];
                mcrc_pkg::REG_RAMP_PERIOD:  r_ramp_period  <= i_cfg_data[9:0];
                mcrc_pkg::REG_DEFAULT_DUTY: r_default_duty <= i_cfg_data[6:0];
                mcrc_pkg::REG_PIVOT_DUTY:   r_pivot_duty   <= i_cfg_data[6:0];
                mcrc_pkg::REG_PIVOT_TICKS:  r_pivot_ticks  <= i_cfg_data;
                mcrc_pkg::REG_DRIVE_TICKS:  r_drive_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and result for the request in the input register
    always_comb begin
        logic [9:0] cnt_inc;
        logic [7:0] up_sum;
        logic [7:0] down_lim;
        logic [6:0] cmd_duty;
        logic       changed;
        logic       timed_cmd;
        logic [1:0] cue;
        logic       rej;

        n_target_duty = r_target_duty;
        n_live_duty   = r_live_duty;
        n_active_dir  = r_active_dir;
        n_last_dir    = r_last_dir;
        n_ramp_cnt    = r_ramp_cnt;
        n_ticks_left  = r_ticks_left;
        n_timed       = r_timed;
        cue           = mcrc_pkg::CUE_NONE;
        rej           = 1'b0;
        cnt_inc       = r_ramp_cnt + 10'd1;
        up_sum        = {1'b0, r_live_duty} + {1'b0, step_c};
        down_lim      = {1'b0, r_target_duty} + {1'b0, step_c};
        changed       = (r_in_cmd.direction != r_last_dir);
        timed_cmd     = 1'b0;
        cmd_duty      = 7'd0;

        if (r_in_func == mcrc_pkg::FUNC_TICK) begin
            // Timed move countdown
            if (r_timed) begin
                n_ticks_left = r_ticks_left - ((r_ticks_left != 16'd0) ? 16'd1 : 16'd0);
                if (n_ticks_left == 16'd0) begin
                    n_timed       = 1'b0;
                    n_active_dir  = mcrc_pkg::DIR_STOP;
                    n_target_duty = 7'd0;
                    n_live_duty   = 7'd0;
                    n_last_dir    = mcrc_pkg::DIR_STOP;
                end
            end
            // Ramp period and slew
            if (cnt_inc >= period_c) begin
                n_ramp_cnt = 10'd0;
                if (!n_timed) begin
                    if (n_live_duty < n_target_duty) begin
                        n_live_duty = (up_sum > {1'b0, n_target_duty}) ? n_target_duty
                                                                      : up_sum[6:0];
                    end else if (n_live_duty > n_target_duty) begin
                        n_live_duty = ({1'b0, n_live_duty} < down_lim) ? n_target_duty
                                                                      : n_live_duty - step_c;
                    end
                end
            end else begin
                n_ramp_cnt = cnt_inc;
            end
        end else if (r_timed) begin
            rej = 1'b1;
        end else if (r_in_cmd.direction <= mcrc_pkg::DIR_BRAKE) begin
            // Timed pivot or run loads the duty directly
            if ((r_in_cmd.direction == mcrc_pkg::DIR_LEFT ||
                 r_in_cmd.direction == mcrc_pkg::DIR_RIGHT) && r_in_cmd.pivot) begin
                timed_cmd    = 1'b1;
                cmd_duty     = pivot_c;
                n_ticks_left = pivot_ticks_c;
            end else if (r_in_cmd.direction == mcrc_pkg::DIR_FORWARD ||
                         r_in_cmd.direction == mcrc_pkg::DIR_BACKWARD) begin
                timed_cmd    = 1'b1;
                cmd_duty     = mcrc_pkg::FULL_DUTY;
                n_ticks_left = drive_ticks_c;
            end
            if (timed_cmd) begin
                n_active_dir  = r_in_cmd.direction;
                n_target_duty = cmd_duty;
                n_live_duty   = cmd_duty;
                n_timed       = 1'b1;
                n_last_dir    = mcrc_pkg::DIR_STOP;
                cue           = changed ? mcrc_pkg::CUE_MOVING : mcrc_pkg::CUE_NONE;
            end else begin
                // Ramped command: new target only
                if (r_in_cmd.direction == mcrc_pkg::DIR_STOP ||
                    r_in_cmd.direction == mcrc_pkg::DIR_BRAKE) begin
                    n_target_duty = 7'd0;
                end else if (r_in_cmd.speed[7]) begin
                    n_target_duty = default_c;
                end else begin
                    n_target_duty = (r_in_cmd.speed[6:0] > mcrc_pkg::FULL_DUTY)
                                    ? mcrc_pkg::FULL_DUTY : r_in_cmd.speed[6:0];
                end
                n_active_dir = r_in_cmd.direction;
                n_last_dir   = r_in_cmd.direction;
                if (changed) begin
                    cue = (r_in_cmd.direction == mcrc_pkg::DIR_STOP ||
                           r_in_cmd.direction == mcrc_pkg::DIR_BRAKE)
                          ? mcrc_pkg::CUE_HALTED : mcrc_pkg::CUE_MOVING;
                end
            end
        end

        // Result from the updated state; braking at rest holds the enable high
        n_out.pad             = 2'b00;
        n_out.timed_busy      = n_timed;
        n_out.rejected        = rej;
        n_out.cue             = cue;
        n_out.enable_duty     = (n_active_dir == mcrc_pkg::DIR_BRAKE && n_live_duty == 7'd0)
                                ? mcrc_pkg::FULL_DUTY : n_live_duty;
        n_out.drive_direction = n_active_dir;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd  <= s_axis_tdata;
            r_in_func <= s_axis_tuser[0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_duty <= 7'd0;
            r_live_duty   <= 7'd0;
            r_active_dir  <= mcrc_pkg::DIR_STOP;
            r_last_dir    <= mcrc_pkg::DIR_STOP;
            r_ramp_cnt    <= 10'd0;
            r_ticks_left  <= 16'd0;
            r_timed       <= 1'b0;
        end else if (advance) begin
            r_target_duty <= n_target_duty;
            r_live_duty   <= n_live_duty;
            r_active_dir  <= n_active_dir;
            r_last_dir    <= n_last_dir;
            r_ramp_cnt    <= n_ramp_cnt;
            r_ticks_left  <= n_ticks_left;
            r_timed       <= n_timed;
        end
    end

endmodule

`default_nettype wire

/* hdl/mcrc_checker.sv */
// Port-level assertions for the motor command ramp controller, bound to the top level.
`default_nettype none

module mcrc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Duty never exceeds full scale
    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:3] <= mcrc_pkg::FULL_DUTY)
        else $error("enable duty above full");

    // A refused command only happens during a timed move and gives no cue
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |->
            m_axis_tdata[13] && m_axis_tdata[11:10] == mcrc_pkg::CUE_NONE)
        else $error("reject without timed move or with cue");

    // Timed moves keep a forward, backward, left or right direction
    a_timed_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |->
            m_axis_tdata[2:0] == mcrc_pkg::DIR_FORWARD ||
            m_axis_tdata[2:0] == mcrc_pkg::DIR_BACKWARD ||
            m_axis_tdata[2:0] == mcrc_pkg::DIR_LEFT ||
            m_axis_tdata[2:0] == mcrc_pkg::DIR_RIGHT)
        else $error("timed move with halted direction");

endmodule

bind motor_command_ramp_controller mcrc_checker u_mcrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* verif/motor_command_ramp_controller_tb.sv */
// Self-checking testbench for the motor command ramp controller stream block.
`default_nettype none

module motor_command_ramp_controller_tb;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RUN_LIMIT       = 4000000;

    // Direction codes outside the bridge set, which the block must ignore
    localparam logic [mcrc_pkg::DIR_W-1:0] DIR_SPARE_LO = 3'd6;
    localparam logic [mcrc_pkg::DIR_W-1:0] DIR_SPARE_HI = 3'd7;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [2:0]  i_cfg_addr     = '0;
    logic [15:0] i_cfg_data     = '0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;   // direction[2:0], speed[10:3], pivot[11], zero
    logic [0:0]  s_axis_tuser   = '0;   // func[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;          // drive_direction[2:0], enable_duty[9:3],
                                        // cue[11:10], rejected[12], timed_busy[13], zero

    // Idle and stall rates in percent, plus the long hold-off request
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_req   = 0;
    int hold_left      = 0;
    int err_count      = 0;

    // Expected drive status, one per accepted request
    mcrc_pkg::t_result pending_drive_q[$];

    // Mirror of the configuration registers
    logic [6:0]  cfg_step        = 7'd5;
    logic [9:0]  cfg_period      = 10'd20;
    logic [6:0]  cfg_default     = 7'd70;
    logic [6:0]  cfg_pivot_duty  = 7'd60;
    logic [15:0] cfg_pivot_ticks = 16'd500;
    logic [15:0] cfg_drive_ticks = 16'd1000;

    // Mirror of the controller state
    logic [mcrc_pkg::DUTY_W-1:0]   tgt_duty  = '0;
    logic [mcrc_pkg::DUTY_W-1:0]   live_duty = '0;
    logic [mcrc_pkg::DIR_W-1:0]    act_dir   = mcrc_pkg::DIR_STOP;
    logic [mcrc_pkg::DIR_W-1:0]    cue_ref_dir = mcrc_pkg::DIR_STOP;
    logic [mcrc_pkg::PERIOD_W-1:0] ramp_cnt  = '0;
    logic [mcrc_pkg::TICKS_W-1:0]  move_left = '0;
    logic                          timed_on  = 1'b0;

    motor_command_ramp_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Direct drive: duty loaded at once, countdown armed
    function automatic void begin_timed_move(input logic [mcrc_pkg::DIR_W-1:0] dir,
                                             input int duty, input int ticks);
        act_dir     = dir;
        tgt_duty    = mcrc_pkg::DUTY_W'(duty);
        live_duty   = mcrc_pkg::DUTY_W'(duty);
        move_left   = mcrc_pkg::TICKS_W'(clamp_int(ticks, 1, 65535));
        timed_on    = 1'b1;
        cue_ref_dir = mcrc_pkg::DIR_STOP;
    endfunction

    // Advance the mirrored state by one request and return the expected status
    function automatic mcrc_pkg::t_result predict_drive(input logic func,
                                                        input mcrc_pkg::t_cmd c);
        mcrc_pkg::t_result          r;
        logic [mcrc_pkg::CUE_W-1:0] cue;
        logic                       rej;
        logic                       changed;
        int                         duty;
        int                         stp;
        int                         lv;
        int                         tg;

        r   = '0;
        cue = mcrc_pkg::CUE_NONE;
        rej = 1'b0;
        if (func == mcrc_pkg::FUNC_TICK) begin
            // countdown of a timed move
            if (timed_on) begin
                if (move_left != 0) move_left = move_left - 1'b1;
                if (move_left == 0) begin
                    timed_on    = 1'b0;
                    act_dir     = mcrc_pkg::DIR_STOP;
                    tgt_duty    = '0;
                    live_duty   = '0;
                    cue_ref_dir = mcrc_pkg::DIR_STOP;
                end
            end
            // ramp period and slew, held off while direct drive is on
            ramp_cnt = ramp_cnt + 1'b1;
            if (int'(ramp_cnt) >= clamp_int(int'(cfg_period), 1,
                                            int'(mcrc_pkg::MAX_PERIOD))) begin
                ramp_cnt = '0;
                if (!timed_on) begin
                    stp = clamp_int(int'(cfg_step), 1, int'(mcrc_pkg::FULL_DUTY));
                    lv  = int'(live_duty);
                    tg  = int'(tgt_duty);
                    if (lv < tg) lv = (lv + stp > tg) ? tg : lv + stp;
                    else if (lv > tg) lv = (lv < tg + stp) ? tg : lv - stp;
                    live_duty = mcrc_pkg::DUTY_W'(lv);
                end
            end
        end else if (timed_on) begin
            rej = 1'b1;
        end else if (c.direction <= mcrc_pkg::DIR_BRAKE) begin
            changed = (c.direction != cue_ref_dir);
            if ((c.direction == mcrc_pkg::DIR_LEFT || c.direction == mcrc_pkg::DIR_RIGHT)
                && c.pivot) begin
                begin_timed_move(c.direction, clamp_int(int'(cfg_pivot_duty), 0,
                                 int'(mcrc_pkg::FULL_DUTY)), int'(cfg_pivot_ticks));
                cue = changed ? mcrc_pkg::CUE_MOVING : mcrc_pkg::CUE_NONE;
            end else if (c.direction == mcrc_pkg::DIR_FORWARD ||
                         c.direction == mcrc_pkg::DIR_BACKWARD) begin
                begin_timed_move(c.direction, int'(mcrc_pkg::FULL_DUTY),
                                 int'(cfg_drive_ticks));
                cue = changed ? mcrc_pkg::CUE_MOVING : mcrc_pkg::CUE_NONE;
            end else begin
                // ramped command: negative speed selects the cruise duty
                if (c.speed[mcrc_pkg::SPEED_W-1])
                    duty = clamp_int(int'(cfg_default), 0, int'(mcrc_pkg::FULL_DUTY));
                else
                    duty = clamp_int(int'(c.speed[mcrc_pkg::SPEED_W-2:0]), 0,
                                     int'(mcrc_pkg::FULL_DUTY));
                if (c.direction == mcrc_pkg::DIR_STOP || c.direction == mcrc_pkg::DIR_BRAKE)
                    duty = 0;
                tgt_duty    = mcrc_pkg::DUTY_W'(duty);
                act_dir     = c.direction;
                cue_ref_dir = c.direction;
                if (changed)
                    cue = (c.direction == mcrc_pkg::DIR_STOP ||
                           c.direction == mcrc_pkg::DIR_BRAKE) ?
                          mcrc_pkg::CUE_HALTED : mcrc_pkg::CUE_MOVING;
            end
        end

        r.drive_direction = act_dir;
        r.enable_duty     = (act_dir == mcrc_pkg::DIR_BRAKE && live_duty == 0) ?
                            mcrc_pkg::FULL_DUTY : live_duty;
        r.cue             = cue;
        r.rejected        = rej;
        r.timed_busy      = timed_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        err_count++;
    endtask

    task automatic check_result(input mcrc_pkg::t_result got);
        mcrc_pkg::t_result want;
        if (pending_drive_q.size() == 0) begin
            report_mismatch("result with no request outstanding", 0, int'(got));
        end else begin
            want = pending_drive_q.pop_front();
            if (got.drive_direction != want.drive_direction)
                report_mismatch("drive_direction", int'(want.drive_direction),
                                int'(got.drive_direction));
            if (got.enable_duty != want.enable_duty)
                report_mismatch("enable_duty", int'(want.enable_duty), int'(got.enable_duty));
            if (got.cue != want.cue)
                report_mismatch("cue", int'(want.cue), int'(got.cue));
            if (got.rejected != want.rejected)
                report_mismatch("rejected", int'(want.rejected), int'(got.rejected));
            if (got.timed_busy != want.timed_busy)
                report_mismatch("timed_busy", int'(want.timed_busy), int'(got.timed_busy));
        end
    endtask

    // Both handshakes are observed at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(mcrc_pkg::t_result'(m_axis_tdata));
            if (s_axis_tvalid && s_axis_tready)
                pending_drive_q.push_back(predict_drive(s_axis_tuser[0],
                                                        mcrc_pkg::t_cmd'(s_axis_tdata)));
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_off_req != 0) begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one request; entered and left at a falling edge
    task automatic send_request(input logic func, input mcrc_pkg::t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= c;
        s_axis_tuser[0] <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [mcrc_pkg::DIR_W-1:0] dir,
                            input logic signed [mcrc_pkg::SPEED_W-1:0] spd,
                            input logic piv);
        mcrc_pkg::t_cmd c;
        c           = '0;
        c.direction = dir;
        c.speed     = spd;
        c.pivot     = piv;
        send_request(mcrc_pkg::FUNC_CMD, c);
    endtask

    // Tick: the other fields carry noise that must be ignored
    task automatic send_tick();
        mcrc_pkg::t_cmd c;
        c           = '0;
        c.direction = mcrc_pkg::DIR_W'($urandom);
        c.speed     = mcrc_pkg::SPEED_W'($urandom);
        c.pivot     = 1'($urandom);
        send_request(mcrc_pkg::FUNC_TICK, c);
    endtask

    // Mostly ticks and valid commands; a few spare direction codes
    task automatic send_random_item(input bit allow_timed);
        logic [mcrc_pkg::DIR_W-1:0]          dir;
        logic signed [mcrc_pkg::SPEED_W-1:0] spd;
        logic                                piv;
        int                                  pick;
        pick = $urandom_range(99);
        if (pick < 58) begin
            send_tick();
        end else begin
            pick = $urandom_range(99);
            if (pick < 6) dir = pick[0] ? DIR_SPARE_HI : DIR_SPARE_LO;
            else dir = mcrc_pkg::DIR_W'($urandom_range(0, 5));
            piv  = 1'($urandom);
            pick = $urandom_range(99);
            if (pick < 30) spd = mcrc_pkg::SPEED_W'(-int'($urandom_range(1, 128)));
            else if (pick < 80) spd = mcrc_pkg::SPEED_W'($urandom_range(0, 100));
            else spd = mcrc_pkg::SPEED_W'($urandom);
            if (!allow_timed) begin
                piv = 1'b0;
                if (dir == mcrc_pkg::DIR_FORWARD) dir = mcrc_pkg::DIR_STOP;
                if (dir == mcrc_pkg::DIR_BACKWARD) dir = mcrc_pkg::DIR_BRAKE;
            end
            send_cmd(dir, spd, piv);
        end
    endtask

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_drive_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mcrc_pkg::CFG_A_W-1:0] addr,
                             input logic [mcrc_pkg::CFG_D_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        case (addr)
            mcrc_pkg::REG_RAMP_STEP:    cfg_step        = data[6:0];
            mcrc_pkg::REG_RAMP_PERIOD:  cfg_period      = data[9:0];
            mcrc_pkg::REG_DEFAULT_DUTY: cfg_default     = data[6:0];
            mcrc_pkg::REG_PIVOT_DUTY:   cfg_pivot_duty  = data[6:0];
            mcrc_pkg::REG_PIVOT_TICKS:  cfg_pivot_ticks = data;
            mcrc_pkg::REG_DRIVE_TICKS:  cfg_drive_ticks = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Every register is rewritten each time; only called while idle
    task automatic load_settings(input int stp, input int per, input int def_duty,
                                 input int piv_duty, input int piv_ticks, input int drv_ticks);
        write_reg(mcrc_pkg::REG_RAMP_STEP,    mcrc_pkg::CFG_D_W'(stp));
        write_reg(mcrc_pkg::REG_RAMP_PERIOD,  mcrc_pkg::CFG_D_W'(per));
        write_reg(mcrc_pkg::REG_DEFAULT_DUTY, mcrc_pkg::CFG_D_W'(def_duty));
        write_reg(mcrc_pkg::REG_PIVOT_DUTY,   mcrc_pkg::CFG_D_W'(piv_duty));
        write_reg(mcrc_pkg::REG_PIVOT_TICKS,  mcrc_pkg::CFG_D_W'(piv_ticks));
        write_reg(mcrc_pkg::REG_DRIVE_TICKS,  mcrc_pkg::CFG_D_W'(drv_ticks));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hand-picked sequence: ignored codes, clamps, brake hold, timed moves
    task automatic test_directed();
        send_tick();
        wait_idle();
        load_settings(30, 1, 70, 60, 2, 3);
        send_cmd(DIR_SPARE_LO, 8'sd50, 1'b1);
        send_cmd(DIR_SPARE_HI, 8'shFF, 1'b0);
        send_cmd(mcrc_pkg::DIR_STOP, 8'sd0, 1'b0);        // no direction change, no cue
        send_cmd(mcrc_pkg::DIR_BRAKE, 8'sd40, 1'b0);      // brake at zero duty holds enable full
        send_tick();
        send_cmd(mcrc_pkg::DIR_LEFT, 8'sd127, 1'b0);      // speed above full is clamped
        send_tick();
        send_tick();
        send_cmd(mcrc_pkg::DIR_RIGHT, 8'sh80, 1'b0);      // negative speed takes the cruise duty
        send_tick();
        send_tick();
        send_cmd(mcrc_pkg::DIR_RIGHT, 8'sd0, 1'b0);
        send_tick();
        send_tick();
        send_cmd(mcrc_pkg::DIR_FORWARD, 8'sd10, 1'b0);    // timed run at full duty
        send_cmd(mcrc_pkg::DIR_LEFT, 8'sd20, 1'b1);       // refused while the run is active
        repeat (3) send_tick();
        send_cmd(mcrc_pkg::DIR_LEFT, 8'sd90, 1'b1);       // timed pivot
        repeat (2) send_tick();
        send_cmd(mcrc_pkg::DIR_BACKWARD, 8'shFF, 1'b1);
        wait_idle();
    endtask

    // Out-of-range register values must be saturated where they are used
    task automatic test_register_saturation();
        load_settings(16'hFF80, 0, 127, 127, 0, 0);
        repeat (60) send_random_item(1'b1);
        wait_idle();
        load_settings(127, 1023, 101, 100, 65535, 65535);
        repeat (40) send_random_item(1'b0);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_item(1'b1);
        wait_idle();
    endtask

    // Result side held off while requests keep coming, so the input backs up
    task automatic test_backpressure();
        load_settings($urandom_range(1, 100), $urandom_range(1, 4), $urandom_range(0, 100),
                      $urandom_range(0, 100), $urandom_range(1, 10), $urandom_range(1, 10));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = HOLD_OFF_CYCLES;
        repeat (80) send_random_item(1'b1);
        wait_idle();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_directed();
        test_register_saturation();

        load_settings(100, 1, 100, 0, 1, 1);
        test_random_traffic(320, 0, 0);
        load_settings(1, 3, 0, 100, 12, 20);
        test_random_traffic(320, 81, 0);
        load_settings($urandom_range(1, 100), $urandom_range(1, 6), $urandom_range(0, 100),
                      $urandom_range(0, 100), $urandom_range(1, 30), $urandom_range(1, 30));
        test_random_traffic(320, 0, 81);
        load_settings(7, 2, 45, 33, 5, 8);
        test_random_traffic(320, 13, 13);

        test_backpressure();

        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #RUN_LIMIT;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

/* motor_command_ramp_controller.f */
hdl/mcrc_pkg.sv
hdl/motor_command_ramp_controller.sv
hdl/mcrc_checker.sv
verif/motor_command_ramp_controller_tb.sv
